[design/otsu_pkg.sv]
// Shared types and constants for the Otsu threshold block.
package otsu_pkg;

	localparam int LEVELS = 256;
	localparam logic [7:0] MAX_LEVEL = 8'd255;

	typedef struct packed {
		logic [7:0] pixel;
		logic       last;
	} sample_t;

	typedef struct packed {
		logic [7:0] threshold;
		logic       overflow;
	} result_t;

	// histogram port control: inc, rd and clr are mutually exclusive
	typedef struct packed {
		logic       inc;
		logic       rd;
		logic       clr;
		logic [7:0] addr;
	} hist_ctrl_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LAST,
		S_RD,
		S_ACC,
		S_MA,
		S_MB,
		S_MQ,
		S_MD2,
		S_ML,
		S_MR,
		S_NEXT,
		S_EMIT
	} state_t;

endpackage

[design/otsu_hist.sv]
// Histogram memory with read-modify-write increment pipeline, read port and clear port.
module otsu_hist #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  otsu_pkg::hist_ctrl_t ctrl,
	output logic [CW-1:0]        rd_data
);

	logic [CW-1:0] mem [otsu_pkg::LEVELS];
	logic [CW-1:0] rd_mem_q;
	logic [CW-1:0] fwd_val_q;
	logic          fwd_q;
	logic          inc_s1;
	logic [7:0]    addr_s1;
	logic [CW-1:0] cur;
	logic [CW-1:0] inc_val;

	assign cur     = fwd_q ? fwd_val_q : rd_mem_q;
	assign inc_val = cur + CW'(1);
	assign rd_data = rd_mem_q;

	always_ff @(posedge clk) begin
		if (ctrl.inc || ctrl.rd) begin
			rd_mem_q <= mem[ctrl.addr];
		end
		if (inc_s1) begin
			mem[addr_s1] <= inc_val;
		end else if (ctrl.clr) begin
			mem[ctrl.addr] <= '0;
		end
	end

	// bypass when the same bin is hit on back-to-back pixels
	always_ff @(posedge clk) begin
		if (ctrl.inc) begin
			fwd_q     <= inc_s1 && (addr_s1 == ctrl.addr);
			fwd_val_q <= inc_val;
			addr_s1   <= ctrl.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1 <= 1'b0;
		end else begin
			inc_s1 <= ctrl.inc;
		end
	end

endmodule

[design/otsu_mul.sv]
// Shared shift-add multiplier, one multiplier bit per cycle, stops when the multiplier runs out.
module otsu_mul #(
	parameter int PW = 112,
	parameter int YW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [PW-1:0] x,
	input  logic [YW-1:0] y,
	output logic          done,
	output logic [PW-1:0] prod
);

	logic          run_q;
	logic [PW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [PW-1:0] acc_q;

	assign done = run_q && (y_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (go) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (run_q && !done) begin
			if (y_q[0]) begin
				acc_q <= acc_q + x_q;
			end
			x_q <= x_q << 1;
			y_q <= y_q >> 1;
		end
	end

endmodule

[design/otsu_threshold_from_histogram.sv]
// Top level: pixel intake, gray totals, threshold search sequencer and clearing pass.
//
// Input channel: a pixel word (sample.pixel, sample.last) is taken at a rising
// edge where start is high and busy is low. While idle the block takes one
// pixel word every cycle; the histogram increment is a read-modify-write, with
// the read registered, and a bypass for repeated gray levels.
// After the word marked last, busy stays high while the threshold is searched.
// Each gray level from the lowest to one below the highest occupied level passes
// the read, accumulate and next states plus six products (four on the first
// level) on the shared shift-add multiplier, each running over the significant
// bits of its multiplier operand. A frame with one level or two adjacent levels
// skips the search and its result comes out through the LAST and EMIT states.
// Result channel: done is high for exactly one cycle with result.threshold and
// result.overflow; the receiver cannot stall it. Overflow reports that pixels
// were dropped because the pixel count reached 2^COUNT_BITS-1.
// After each result, and after reset, a clearing pass zeroes the 256 bins,
// one per cycle, while busy is high.
module otsu_threshold_from_histogram #(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  otsu_pkg::sample_t sample,
	output logic              done,
	output otsu_pkg::result_t result
);

	localparam int CW  = COUNT_BITS;
	localparam int SW  = CW + 8;
	localparam int DW  = 2 * CW + 8;
	localparam int QW  = 2 * CW;
	localparam int D2W = 4 * CW + 16;
	localparam int PW  = 6 * CW + 16;
	localparam logic [CW-1:0] CMAX = '1;

	otsu_pkg::state_t     state_q, state_d;
	otsu_pkg::hist_ctrl_t hctrl;

	logic [CW-1:0]  total_q;
	logic [SW-1:0]  gray_q;
	logic           sat_q;
	logic [7:0]     lo_q, hi_q, t_q, best_t_q, clr_q;
	logic           have_q, issued_q;
	logic [CW-1:0]  back_q;
	logic [SW-1:0]  sumb_q;
	logic [DW-1:0]  a_q, d_q;
	logic [QW-1:0]  q_q, best_q_q;
	logic [D2W-1:0] d2_q, best_d2_q;
	logic [PW-1:0]  lhs_q;

	logic [CW-1:0]  rd_data;
	logic [CW-1:0]  fore;
	logic           accept, counted, mul_state, mul_go, mul_done, trivial;
	logic [PW-1:0]  mul_x, mul_prod;
	logic [DW-1:0]  mul_y;

	assign accept  = start && !busy;
	assign counted = accept && (total_q != CMAX);
	assign fore    = total_q - back_q;
	assign trivial = (hi_q == lo_q) || ((lo_q + 8'd1) == hi_q);

	otsu_hist #(.CW(CW)) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hctrl),
		.rd_data (rd_data)
	);

	otsu_mul #(.PW(PW), .YW(DW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= otsu_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		done      = 1'b0;
		hctrl     = '0;
		mul_state = 1'b0;
		mul_x     = '0;
		mul_y     = '0;
		case (state_q)
			otsu_pkg::S_CLR: begin
				hctrl.clr  = 1'b1;
				hctrl.addr = clr_q;
				if (clr_q == otsu_pkg::MAX_LEVEL) begin
					state_d = otsu_pkg::S_IDLE;
				end
			end
			otsu_pkg::S_IDLE: begin
				busy       = 1'b0;
				hctrl.inc  = counted;
				hctrl.addr = sample.pixel;
				if (accept && sample.last) begin
					state_d = otsu_pkg::S_LAST;
				end
			end
			otsu_pkg::S_LAST: begin
				state_d = trivial ? otsu_pkg::S_EMIT : otsu_pkg::S_RD;
			end
			otsu_pkg::S_RD: begin
				hctrl.rd   = 1'b1;
				hctrl.addr = t_q;
				state_d    = otsu_pkg::S_ACC;
			end
			otsu_pkg::S_ACC: begin
				state_d = otsu_pkg::S_MA;
			end
			otsu_pkg::S_MA: begin
				mul_state = 1'b1;
				mul_x     = PW'(sumb_q);
				mul_y     = DW'(total_q);
				if (mul_done) begin
					state_d = otsu_pkg::S_MB;
				end
			end
			otsu_pkg::S_MB: begin
				mul_state = 1'b1;
				mul_x     = PW'(gray_q);
				mul_y     = DW'(back_q);
				if (mul_done) begin
					state_d = otsu_pkg::S_MQ;
				end
			end
			otsu_pkg::S_MQ: begin
				mul_state = 1'b1;
				mul_x     = PW'(back_q);
				mul_y     = DW'(fore);
				if (mul_done) begin
					state_d = otsu_pkg::S_MD2;
				end
			end
			otsu_pkg::S_MD2: begin
				mul_state = 1'b1;
				mul_x     = PW'(d_q);
				mul_y     = d_q;
				if (mul_done) begin
					state_d = have_q ? otsu_pkg::S_ML : otsu_pkg::S_NEXT;
				end
			end
			otsu_pkg::S_ML: begin
				mul_state = 1'b1;
				mul_x     = PW'(d2_q);
				mul_y     = DW'(best_q_q);
				if (mul_done) begin
					state_d = otsu_pkg::S_MR;
				end
			end
			otsu_pkg::S_MR: begin
				mul_state = 1'b1;
				mul_x     = PW'(best_d2_q);
				mul_y     = DW'(q_q);
				if (mul_done) begin
					state_d = otsu_pkg::S_NEXT;
				end
			end
			otsu_pkg::S_NEXT: begin
				state_d = ((t_q + 8'd1) == hi_q) ? otsu_pkg::S_EMIT : otsu_pkg::S_RD;
			end
			otsu_pkg::S_EMIT: begin
				done    = 1'b1;
				state_d = otsu_pkg::S_CLR;
			end
			default: begin
				state_d = otsu_pkg::S_CLR;
			end
		endcase
	end

	assign mul_go           = mul_state && !issued_q;
	assign result.threshold = best_t_q;
	assign result.overflow  = sat_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			gray_q   <= '0;
			sat_q    <= 1'b0;
			have_q   <= 1'b0;
			issued_q <= 1'b0;
			clr_q    <= '0;
		end else begin
			issued_q <= mul_state && !mul_done;
			case (state_q)
				otsu_pkg::S_CLR: begin
					clr_q <= clr_q + 8'd1;
				end
				otsu_pkg::S_IDLE: begin
					if (counted) begin
						total_q <= total_q + CW'(1);
						gray_q  <= gray_q + SW'(sample.pixel);
					end else if (accept) begin
						sat_q <= 1'b1;
					end
				end
				otsu_pkg::S_LAST: begin
					have_q <= 1'b0;
				end
				otsu_pkg::S_MD2: begin
					if (mul_done) begin
						have_q <= 1'b1;
					end
				end
				otsu_pkg::S_EMIT: begin
					total_q <= '0;
					gray_q  <= '0;
					sat_q   <= 1'b0;
					clr_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			otsu_pkg::S_IDLE: begin
				if (counted) begin
					if (total_q == '0) begin
						lo_q <= sample.pixel;
						hi_q <= sample.pixel;
					end else begin
						if (sample.pixel < lo_q) lo_q <= sample.pixel;
						if (sample.pixel > hi_q) hi_q <= sample.pixel;
					end
				end
			end
			otsu_pkg::S_LAST: begin
				back_q   <= '0;
				sumb_q   <= '0;
				t_q      <= lo_q;
				best_t_q <= lo_q;
			end
			otsu_pkg::S_ACC: begin
				back_q <= back_q + rd_data;
				sumb_q <= sumb_q + SW'(rd_data) * SW'(t_q);
			end
			otsu_pkg::S_MA: begin
				if (mul_done) a_q <= mul_prod[DW-1:0];
			end
			otsu_pkg::S_MB: begin
				if (mul_done) begin
					d_q <= (a_q >= mul_prod[DW-1:0]) ? (a_q - mul_prod[DW-1:0])
						: (mul_prod[DW-1:0] - a_q);
				end
			end
			otsu_pkg::S_MQ: begin
				if (mul_done) q_q <= mul_prod[QW-1:0];
			end
			otsu_pkg::S_MD2: begin
				if (mul_done) begin
					d2_q <= mul_prod[D2W-1:0];
					if (!have_q) begin
						best_t_q  <= t_q;
						best_d2_q <= mul_prod[D2W-1:0];
						best_q_q  <= q_q;
					end
				end
			end
			otsu_pkg::S_ML: begin
				if (mul_done) lhs_q <= mul_prod;
			end
			otsu_pkg::S_MR: begin
				if (mul_done && (lhs_q > mul_prod)) begin
					best_t_q  <= t_q;
					best_d2_q <= d2_q;
					best_q_q  <= q_q;
				end
			end
			otsu_pkg::S_NEXT: begin
				t_q <= t_q + 8'd1;
			end
			default: begin
			end
		endcase
	end

endmodule
